// ===== design/tbed_pkg.sv =====
// ----------------------------------------------------------------------------
// tbed_pkg: shared types and constants of the two-beam direction detector
// Mode encoding, configuration and state records, result record, LED colors
// and configuration register indexes.
// ----------------------------------------------------------------------------
package tbed_pkg;

  // Machine modes, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_ARMED    = 5'b00010,
    MODE_RINGING  = 5'b00100,
    MODE_OUTGOING = 5'b01000,
    MODE_COOLDOWN = 5'b10000
  } mode_e;

  // Codes of the modes as reported on the result channel.
  localparam logic [2:0] CODE_IDLE     = 3'd0;
  localparam logic [2:0] CODE_ARMED    = 3'd1;
  localparam logic [2:0] CODE_RINGING  = 3'd2;
  localparam logic [2:0] CODE_OUTGOING = 3'd3;
  localparam logic [2:0] CODE_COOLDOWN = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_COOLDOWN_TICKS     = 3'd0;
  localparam logic [2:0] REG_BELL_TICKS         = 3'd1;
  localparam logic [2:0] REG_PASS_TIMEOUT_TICKS = 3'd2;
  localparam logic [2:0] REG_SENSOR_A_IDLE      = 3'd3;
  localparam logic [2:0] REG_SENSOR_B_IDLE      = 3'd4;

  // Register reset values.
  localparam logic [15:0] COOLDOWN_TICKS_RST     = 16'd2000;
  localparam logic [15:0] BELL_TICKS_RST         = 16'd1500;
  localparam logic [15:0] PASS_TIMEOUT_TICKS_RST = 16'd1000;

  // Saturation value of the tick timer.
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // LED levels.
  localparam logic [7:0] LED_FULL = 8'd255;
  localparam logic [7:0] LED_PART = 8'd155;
  localparam logic [7:0] LED_OFF  = 8'd0;

  typedef struct packed {
    logic [15:0] cooldown_ticks;
    logic [15:0] bell_ticks;
    logic [15:0] pass_timeout_ticks;
    logic        sensor_a_idle_level;
    logic        sensor_b_idle_level;
  } tbed_cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] elapsed;
    logic [15:0] entries;
    logic [15:0] exits;
  } tbed_state_t;

  typedef struct packed {
    logic        bell_on;
    logic [2:0]  state_code;
    logic [15:0] entry_count;
    logic [15:0] exit_count;
    logic [7:0]  led_red;
    logic [7:0]  led_green;
    logic [7:0]  led_blue;
  } tbed_result_t;

endpackage

// ===== design/tbed_step.sv =====
// ----------------------------------------------------------------------------
// tbed_step: next-state and result logic for one tick
// Takes the registered machine state, the configuration and the two sensor
// levels of one tick, and forms the following state and the result record.
// ----------------------------------------------------------------------------
module tbed_step import tbed_pkg::*; (
  input  tbed_state_t  state_i,
  input  tbed_cfg_t    cfg_i,
  input  logic         sensor_a_i,
  input  logic         sensor_b_i,
  output tbed_state_t  state_o,
  output tbed_result_t result_o
);

  logic        act_a;
  logic        act_b;
  logic [15:0] elapsed_inc;

  // A sensor is active when its level differs from its idle level.
  assign act_a = sensor_a_i ^ cfg_i.sensor_a_idle_level;
  assign act_b = sensor_b_i ^ cfg_i.sensor_b_idle_level;

  // The timer advances in every mode but idle and saturates at its top.
  assign elapsed_inc = ((state_i.mode != MODE_IDLE) && (state_i.elapsed != TICK_MAX)) ?
                       state_i.elapsed + 16'd1 : state_i.elapsed;

  // Mode transitions.
  always_comb begin
    state_o         = state_i;
    state_o.elapsed = elapsed_inc;
    unique case (state_i.mode)
      MODE_ARMED: begin
        if (act_b) begin
          state_o.mode    = MODE_RINGING;
          state_o.elapsed = '0;
        end else if (elapsed_inc >= cfg_i.pass_timeout_ticks) begin
          state_o.mode = MODE_IDLE;
        end
      end
      MODE_RINGING: begin
        if (elapsed_inc >= cfg_i.bell_ticks) begin
          state_o.entries = state_i.entries + 16'd1;
          state_o.mode    = MODE_COOLDOWN;
          state_o.elapsed = '0;
        end
      end
      MODE_OUTGOING: begin
        if (act_a) begin
          state_o.exits = state_i.exits + 16'd1;
          state_o.mode  = MODE_IDLE;
        end else if (elapsed_inc >= cfg_i.pass_timeout_ticks) begin
          state_o.mode = MODE_IDLE;
        end
      end
      MODE_COOLDOWN: begin
        // Expiry wins over activity; activity restarts the quiet period.
        if (elapsed_inc >= cfg_i.cooldown_ticks) begin
          state_o.mode = MODE_IDLE;
        end else if (act_a || act_b) begin
          state_o.elapsed = '0;
        end
      end
      default: begin
        // Idle: the outer sensor has priority when both are active.
        if (act_a) begin
          state_o.mode    = MODE_ARMED;
          state_o.elapsed = '0;
        end else if (act_b) begin
          state_o.mode    = MODE_OUTGOING;
          state_o.elapsed = '0;
        end
      end
    endcase
  end

  // Result for the state after the tick.
  always_comb begin
    result_o.bell_on     = 1'b0;
    result_o.entry_count = state_o.entries;
    result_o.exit_count  = state_o.exits;
    unique case (state_o.mode)
      MODE_ARMED: begin
        result_o.state_code = CODE_ARMED;
        result_o.led_red    = LED_PART;
        result_o.led_green  = LED_FULL;
        result_o.led_blue   = LED_OFF;
      end
      MODE_RINGING: begin
        result_o.bell_on    = 1'b1;
        result_o.state_code = CODE_RINGING;
        result_o.led_red    = LED_FULL;
        result_o.led_green  = LED_OFF;
        result_o.led_blue   = LED_OFF;
      end
      MODE_OUTGOING: begin
        result_o.state_code = CODE_OUTGOING;
        result_o.led_red    = LED_OFF;
        result_o.led_green  = LED_FULL;
        result_o.led_blue   = LED_FULL;
      end
      MODE_COOLDOWN: begin
        result_o.state_code = CODE_COOLDOWN;
        result_o.led_red    = LED_OFF;
        result_o.led_green  = LED_OFF;
        result_o.led_blue   = LED_FULL;
      end
      default: begin
        result_o.state_code = CODE_IDLE;
        result_o.led_red    = LED_OFF;
        result_o.led_green  = LED_FULL;
        result_o.led_blue   = LED_OFF;
      end
    endcase
  end

endmodule

// ===== design/two_beam_entry_direction_fsm.sv =====
// ----------------------------------------------------------------------------
// two_beam_entry_direction_fsm: two-beam entry and exit detector with bell
// Each request is one millisecond tick with the levels of the outer (A) and
// inner (B) beam sensors; each tick yields one result with the bell level,
// the mode code, the entry and exit counters and the LED color.
//
// Usage:
// - Tick channel in_valid_i / in_ready_o, result channel out_valid_o /
//   out_ready_i; a request moves when valid and ready are both high.
// - The machine state and the result register are updated in the cycle a
//   tick is accepted; the result is valid from the next cycle on.
// - One tick per cycle is sustained while out_ready_i is high; the rate is
//   set by the single result register, refilled in the same cycle it is emptied.
// - When the receiver stalls, the held result blocks in_ready_o until taken.
// - Reset clears the state to idle, zeroes timer and counters and loads the
//   register defaults (cooldown 2000, bell 1500, pass timeout 1000, idle
//   levels 0). Registers are written through cfg_we_i / cfg_index_i /
//   cfg_data_i while no tick is in flight; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module two_beam_entry_direction_fsm import tbed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        sensor_a_i,
  input  logic        sensor_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        bell_on_o,
  output logic [2:0]  state_code_o,
  output logic [15:0] entry_count_o,
  output logic [15:0] exit_count_o,
  output logic [7:0]  led_red_o,
  output logic [7:0]  led_green_o,
  output logic [7:0]  led_blue_o
);

  tbed_cfg_t    cfg_q;
  tbed_state_t  state_q;
  tbed_state_t  state_d;
  tbed_result_t result_q;
  tbed_result_t result_d;
  logic         out_valid_q;
  logic         accept;

  // Accept a tick whenever the result register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ticks      <= COOLDOWN_TICKS_RST;
      cfg_q.bell_ticks          <= BELL_TICKS_RST;
      cfg_q.pass_timeout_ticks  <= PASS_TIMEOUT_TICKS_RST;
      cfg_q.sensor_a_idle_level <= 1'b0;
      cfg_q.sensor_b_idle_level <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COOLDOWN_TICKS:     cfg_q.cooldown_ticks      <= cfg_data_i;
        REG_BELL_TICKS:         cfg_q.bell_ticks          <= cfg_data_i;
        REG_PASS_TIMEOUT_TICKS: cfg_q.pass_timeout_ticks  <= cfg_data_i;
        REG_SENSOR_A_IDLE:      cfg_q.sensor_a_idle_level <= cfg_data_i[0];
        REG_SENSOR_B_IDLE:      cfg_q.sensor_b_idle_level <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Tick logic.
  tbed_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .sensor_a_i (sensor_a_i),
    .sensor_b_i (sensor_b_i),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // Machine state, updated once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_IDLE;
      state_q.elapsed <= '0;
      state_q.entries <= '0;
      state_q.exits   <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bell_on_o     = result_q.bell_on;
  assign state_code_o  = result_q.state_code;
  assign entry_count_o = result_q.entry_count;
  assign exit_count_o  = result_q.exit_count;
  assign led_red_o     = result_q.led_red;
  assign led_green_o   = result_q.led_green;
  assign led_blue_o    = result_q.led_blue;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: two-beam entry direction detector
// Drives sensor ticks and takes results over valid/ready, with random idle
// cycles on both sides. A scoreboard predicts the mode, timer, counters and
// LED color of every tick and checks each result in order. Directed walks
// cover beam priority, expiry and activity in cooldown, exits and timeouts;
// a back-to-back burst covers zero limits with inverted idle levels; the
// rest is random passages, noise and register settings.
// ----------------------------------------------------------------------------
module testbench;
  import tbed_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_GAP      = 13;
  localparam int unsigned RANDOM_TICKS = 1500;
  localparam int unsigned PHASE_TICKS  = 150;
  localparam int unsigned FAST_PASSES  = 40;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  // Predicts every tick of the detector and checks results in order.
  class tick_scoreboard;
    tbed_cfg_t    cfg;
    logic [2:0]   mode;
    logic [15:0]  elapsed;
    logic [15:0]  entries;
    logic [15:0]  exits;
    tbed_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  ticks;
    int unsigned  results;
    int unsigned  mode_ticks[5];

    function new();
      cfg.cooldown_ticks      = COOLDOWN_TICKS_RST;
      cfg.bell_ticks          = BELL_TICKS_RST;
      cfg.pass_timeout_ticks  = PASS_TIMEOUT_TICKS_RST;
      cfg.sensor_a_idle_level = 1'b0;
      cfg.sensor_b_idle_level = 1'b0;
      mode    = CODE_IDLE;
      elapsed = '0;
      entries = '0;
      exits   = '0;
      errors  = 0;
      ticks   = 0;
      results = 0;
      foreach (mode_ticks[i]) mode_ticks[i] = 0;
    endfunction

    // Mirror a register write; unknown indexes change nothing.
    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_COOLDOWN_TICKS:     cfg.cooldown_ticks = data;
        REG_BELL_TICKS:         cfg.bell_ticks = data;
        REG_PASS_TIMEOUT_TICKS: cfg.pass_timeout_ticks = data;
        REG_SENSOR_A_IDLE:      cfg.sensor_a_idle_level = data[0];
        REG_SENSOR_B_IDLE:      cfg.sensor_b_idle_level = data[0];
        default: ;
      endcase
    endfunction

    // Advance the machine by one accepted tick and queue the result it gives.
    function void note_tick(logic a, logic b);
      logic         act_a;
      logic         act_b;
      tbed_result_t r;
      act_a = (a != cfg.sensor_a_idle_level);
      act_b = (b != cfg.sensor_b_idle_level);
      ticks++;

      // The timer runs in every mode but idle and stops at its maximum.
      if (mode != CODE_IDLE && elapsed != TICK_MAX) elapsed = elapsed + 16'd1;

      case (mode)
        CODE_ARMED: begin
          if (act_b) begin
            mode    = CODE_RINGING;
            elapsed = '0;
          end else if (elapsed >= cfg.pass_timeout_ticks) begin
            mode = CODE_IDLE;
          end
        end
        CODE_RINGING: begin
          if (elapsed >= cfg.bell_ticks) begin
            entries = entries + 16'd1;
            mode    = CODE_COOLDOWN;
            elapsed = '0;
          end
        end
        CODE_OUTGOING: begin
          if (act_a) begin
            exits = exits + 16'd1;
            mode  = CODE_IDLE;
          end else if (elapsed >= cfg.pass_timeout_ticks) begin
            mode = CODE_IDLE;
          end
        end
        CODE_COOLDOWN: begin
          // Expiry wins over activity on the same tick.
          if (elapsed >= cfg.cooldown_ticks) mode = CODE_IDLE;
          else if (act_a || act_b) elapsed = '0;
        end
        default: begin
          // The outer beam wins when both are active.
          if (act_a) begin
            mode    = CODE_ARMED;
            elapsed = '0;
          end else if (act_b) begin
            mode    = CODE_OUTGOING;
            elapsed = '0;
          end
        end
      endcase

      // Color of the mode after the tick.
      case (mode)
        CODE_ARMED: begin
          r.led_red = LED_PART; r.led_green = LED_FULL; r.led_blue = LED_OFF;
        end
        CODE_RINGING: begin
          r.led_red = LED_FULL; r.led_green = LED_OFF; r.led_blue = LED_OFF;
        end
        CODE_OUTGOING: begin
          r.led_red = LED_OFF; r.led_green = LED_FULL; r.led_blue = LED_FULL;
        end
        CODE_COOLDOWN: begin
          r.led_red = LED_OFF; r.led_green = LED_OFF; r.led_blue = LED_FULL;
        end
        default: begin
          r.led_red = LED_OFF; r.led_green = LED_FULL; r.led_blue = LED_OFF;
        end
      endcase
      r.bell_on     = (mode == CODE_RINGING);
      r.state_code  = mode;
      r.entry_count = entries;
      r.exit_count  = exits;
      expected_q.push_back(r);
      mode_ticks[mode]++;
    endfunction

    // Compare one result with the oldest prediction.
    function void check_result(tbed_result_t got);
      tbed_result_t exp;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Result %0d arrived with no tick waiting for it.", results);
        return;
      end
      exp = expected_q.pop_front();
      if (got.bell_on !== exp.bell_on || got.state_code !== exp.state_code ||
          got.entry_count !== exp.entry_count || got.exit_count !== exp.exit_count ||
          got.led_red !== exp.led_red || got.led_green !== exp.led_green ||
          got.led_blue !== exp.led_blue) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Result %0d mismatch, expected: bell %0b mode %0d in %0d out %0d rgb %0d/%0d/%0d",
                   results, exp.bell_on, exp.state_code, exp.entry_count, exp.exit_count,
                   exp.led_red, exp.led_green, exp.led_blue);
          $display("  actual: bell %0b mode %0d in %0d out %0d rgb %0d/%0d/%0d",
                   got.bell_on, got.state_code, got.entry_count, got.exit_count,
                   got.led_red, got.led_green, got.led_blue);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        sensor_a_i  = 1'b0;
  logic        sensor_b_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        bell_on_o;
  logic [2:0]  state_code_o;
  logic [15:0] entry_count_o;
  logic [15:0] exit_count_o;
  logic [7:0]  led_red_o;
  logic [7:0]  led_green_o;
  logic [7:0]  led_blue_o;

  // When clear, neither side inserts idle cycles.
  bit             gaps_on  = 1'b1;
  int unsigned    cfg_sets = 0;
  tick_scoreboard sb       = new();

  two_beam_entry_direction_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sensor_a_i    (sensor_a_i),
    .sensor_b_i    (sensor_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bell_on_o     (bell_on_o),
    .state_code_o  (state_code_o),
    .entry_count_o (entry_count_o),
    .exit_count_o  (exit_count_o),
    .led_red_o     (led_red_o),
    .led_green_o   (led_green_o),
    .led_blue_o    (led_blue_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Present one tick request and hold it until accepted. Valid is lowered
  // only when a gap follows, so a back-to-back request keeps it high.
  task automatic send_tick(input logic a, input logic b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensor_a_i <= a;
    sensor_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(a, b);
  endtask

  // Tick given as beam activity, translated through the current idle levels.
  task automatic send_active(input bit act_a, input bit act_b);
    send_tick(act_a ^ sb.cfg.sensor_a_idle_level, act_b ^ sb.cfg.sensor_b_idle_level);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all registers plus one unused index. Idle levels carry random
  // upper bits that the block must drop.
  task automatic write_cfg(input logic [15:0] cool, input logic [15:0] bell,
                           input logic [15:0] pass, input logic a_lvl,
                           input logic b_lvl);
    logic [2:0]  idx[6];
    logic [15:0] val[6];
    logic [14:0] junk_a;
    logic [14:0] junk_b;
    junk_a = $urandom();
    junk_b = $urandom();
    idx = '{REG_COOLDOWN_TICKS, REG_BELL_TICKS, REG_PASS_TIMEOUT_TICKS,
            REG_SENSOR_A_IDLE, REG_SENSOR_B_IDLE,
            REG_SENSOR_B_IDLE + 3'($urandom_range(1, 3))};
    val = '{cool, bell, pass, {junk_a, a_lvl}, {junk_b, b_lvl}, 16'($urandom())};
    foreach (idx[i]) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  // Mostly short limits, sometimes the extremes or any 16-bit value.
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  // One random passage: walking in or out, noise, then some quiet ticks.
  task automatic walk_pattern();
    gaps_on = ($urandom_range(0, 5) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(1, 3)) send_active(1'b1, 1'b0);
        repeat ($urandom_range(0, 2)) send_active(1'b1, 1'b1);
        repeat ($urandom_range(1, 3)) send_active(1'b0, 1'b1);
      end
      4, 5, 6: begin
        repeat ($urandom_range(1, 3)) send_active(1'b0, 1'b1);
        repeat ($urandom_range(0, 2)) send_active(1'b1, 1'b1);
        repeat ($urandom_range(1, 3)) send_active(1'b1, 1'b0);
      end
      7, 8: begin
        repeat ($urandom_range(1, 6))
          send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 10)) send_active(1'b0, 1'b0);
  endtask

  // Result side: random stalls, each result checked when taken.
  initial begin : result_sink
    tbed_result_t got;
    int unsigned  gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.bell_on     = bell_on_o;
      got.state_code  = state_code_o;
      got.entry_count = entry_count_o;
      got.exit_count  = exit_count_o;
      got.led_red     = led_red_o;
      got.led_green   = led_green_o;
      got.led_blue    = led_blue_o;
      sb.check_result(got);
    end
  end

  // Cycle limit for a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d results outstanding.", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    // Beam activity pairs {A, B} of the directed walk.
    bit [1:0]    walk[] = '{2'b00, 2'b11, 2'b01, 2'b11, 2'b01, 2'b10, 2'b00, 2'b00,
                            2'b01, 2'b01, 2'b10, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00,
                            2'b10, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00};
    int unsigned random_start;
    int unsigned phase_start;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk with short limits: both beams at once from idle, beams
    // ignored while ringing, activity restarting cooldown, expiry winning
    // over activity, an exit, an outgoing timeout and an armed timeout.
    write_cfg(16'd3, 16'd2, 16'd4, 1'b0, 1'b0);
    foreach (walk[i]) send_active(walk[i][1], walk[i][0]);
    drain();

    // Zero limits and inverted idle levels: fast entries and exits sent
    // back to back without idle cycles on either side.
    write_cfg(16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
    gaps_on = 1'b0;
    send_active(1'b0, 1'b0);
    repeat (FAST_PASSES) begin
      send_active(1'b1, 1'b0);
      send_active(1'b0, 1'b1);
      send_active(1'b0, 1'b0);
      send_active(1'b0, 1'b0);
      send_active(1'b0, 1'b1);
      send_active(1'b1, 1'b0);
    end
    drain();
    gaps_on = 1'b1;

    // Random phases, each with its own register setting.
    random_start = sb.ticks;
    while (sb.ticks - random_start < RANDOM_TICKS) begin
      drain();
      write_cfg(pick_limit(), pick_limit(), pick_limit(),
                $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      phase_start = sb.ticks;
      while (sb.ticks - phase_start < PHASE_TICKS) begin
        walk_pattern();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end
    drain();

    $display("Checked %0d results from %0d ticks over %0d register settings.",
             sb.results, sb.ticks, cfg_sets);
    $display("Ticks ended idle %0d, armed %0d, ringing %0d, outgoing %0d, cooldown %0d.",
             sb.mode_ticks[CODE_IDLE], sb.mode_ticks[CODE_ARMED],
             sb.mode_ticks[CODE_RINGING], sb.mode_ticks[CODE_OUTGOING],
             sb.mode_ticks[CODE_COOLDOWN]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tbed_pkg.sv
design/tbed_step.sv
design/two_beam_entry_direction_fsm.sv
dv/testbench.sv
